// ===== hw/rtl/idp_pkg.sv =====
// Shared types and constants of the isentropic density and pressure unit.
`timescale 1ns / 1ps

package idp_pkg;

  localparam int VEL_W     = 16;            // one Q4.12 velocity component
  localparam int NUM_COMP  = 3;             // components carried on the ports
  localparam int VEC_W     = VEL_W * NUM_COMP;
  localparam int SQ_W      = 31;            // square of one component
  localparam int DEN_W     = 32;            // numerator and denominator, Q8.24
  localparam int RATIO_W   = 38;            // ratio in Q.32, below 40
  localparam int LO_W      = RATIO_W - DEN_W;
  localparam int ROOT_W    = 31;            // sqrt(ratio) in Q.28
  localparam int ROOT_REM_W = ROOT_W + 3;
  localparam int R2_W      = 43;
  localparam int R3_W      = 48;
  localparam int PRS_W     = 35;            // pressure before the 5/7 scale
  localparam int OUT_W     = 32;

  localparam int DIV_STEPS  = RATIO_W;
  localparam int SQRT_STEPS = (RATIO_W + 24) / 2;

  localparam int CFG_IW  = 2;
  localparam int IN_TW   = VEC_W;
  localparam int OUT_TW  = VEC_W + 2 * OUT_W;

  localparam logic [DEN_W-1:0] BASE   = 32'd83886080;    // 5.0 in Q8.24
  localparam logic [31:0]      RECIP7 = 32'd2454267026;  // floor(2^34 / 7)
  localparam logic [37:0]      PRS_SAT = 38'h7_0000_0000; // 7 * 2^32

  typedef enum logic [CFG_IW-1:0] {
    REG_FS_X = 2'd0,
    REG_FS_Y = 2'd1,
    REG_FS_Z = 2'd2
  } cfg_idx_t;

endpackage

// ===== hw/rtl/isentropic_density_pressure_unit.sv =====
// Isentropic density and pressure from potential gradients, one point per cycle unless the output stalls.
//
// Usage: the slave stream (in_tvalid/in_tready/in_tdata) takes one point per
// transfer: grad_x, grad_y, grad_z, each signed Q4.12, from the lowest bit up.
// The master stream returns one result per point: vel_x, vel_y, vel_z
// (signed Q4.12, saturated), then density and pressure (unsigned Q16.16).
// The cfg channel writes the free-stream components; cfg_ready is always high
// and writes are meant for idle periods. Index 3 is ignored.
// One point enters per cycle while the output is not stalled: the divider (38
// stages, one quotient bit each) and the square root (31 stages, one root bit
// each) are fully pipelined, and the multiplies are split into 32-bit partial
// products over registered stages.
// Reset clears the free-stream registers to zero and empties the pipeline.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline holds and in_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module isentropic_density_pressure_unit #(
  parameter int DIM = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [idp_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [idp_pkg::VEL_W-1:0]    cfg_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [idp_pkg::IN_TW-1:0]    in_tdata,   // grad_x, grad_y, grad_z
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [idp_pkg::OUT_TW-1:0]   out_tdata   // vel_x, vel_y, vel_z, density, pressure
);
  import idp_pkg::*;

  logic en;
  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // Free-stream registers.
  logic signed [VEL_W-1:0] fs_r [NUM_COMP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COMP; i++) fs_r[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_FS_X: fs_r[0] <= cfg_data;
        REG_FS_Y: fs_r[1] <= cfg_data;
        REG_FS_Z: fs_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: saturated velocity sums.
  logic [VEL_W-1:0] vel_nxt [NUM_COMP];
  logic [SQ_W-1:0]  vsq_nxt [NUM_COMP];
  logic [SQ_W-1:0]  fsq_nxt [NUM_COMP];
  logic             s0_valid_r;
  logic [VEC_W-1:0] s0_vel_r;

  for (genvar d = 0; d < NUM_COMP; d++) begin : g_comp
    if (d < DIM) begin : g_on
      logic signed [VEL_W:0]     sum;
      logic signed [VEL_W-1:0]   v;
      logic signed [2*VEL_W-1:0] vp;
      logic signed [2*VEL_W-1:0] fp;
      assign sum = (VEL_W+1)'(fs_r[d]) + (VEL_W+1)'($signed(in_tdata[VEL_W*d +: VEL_W]));
      always_comb begin
        if (sum > 17'sd32767) vel_nxt[d] = 16'h7fff;
        else if (sum < -17'sd32768) vel_nxt[d] = 16'h8000;
        else vel_nxt[d] = sum[VEL_W-1:0];
      end
      assign v  = $signed(s0_vel_r[VEL_W*d +: VEL_W]);
      assign vp = (2*VEL_W)'(v) * (2*VEL_W)'(v);
      assign fp = (2*VEL_W)'(fs_r[d]) * (2*VEL_W)'(fs_r[d]);
      assign vsq_nxt[d] = vp[SQ_W-1:0];
      assign fsq_nxt[d] = fp[SQ_W-1:0];
    end else begin : g_off
      assign vel_nxt[d] = '0;
      assign vsq_nxt[d] = '0;
      assign fsq_nxt[d] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) s0_vel_r <= {vel_nxt[2], vel_nxt[1], vel_nxt[0]};
  end

  // Stage 1: squared components.
  logic             s1_valid_r;
  logic [SQ_W-1:0]  s1_vsq_r [NUM_COMP];
  logic [SQ_W-1:0]  s1_fsq_r [NUM_COMP];
  logic [VEC_W-1:0] s1_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (en) s1_valid_r <= s0_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vsq_r <= vsq_nxt;
      s1_fsq_r <= fsq_nxt;
      s1_vel_r <= s0_vel_r;
    end
  end

  // Divider: index 0 holds numerator and denominator, each later stage one
  // quotient bit of num * 2^32 / den.
  logic             dv_valid_r [0:DIV_STEPS];
  logic [DEN_W-1:0] dv_rem_r   [0:DIV_STEPS];
  logic [RATIO_W-1:0] dv_q_r   [0:DIV_STEPS];
  logic [LO_W-1:0]  dv_lo_r    [0:DIV_STEPS];
  logic [DEN_W-1:0] dv_den_r   [0:DIV_STEPS];
  logic [VEC_W-1:0] dv_vel_r   [0:DIV_STEPS];
  logic [DEN_W-1:0] num_nxt;
  logic [DEN_W-1:0] den_nxt;

  assign num_nxt = BASE + DEN_W'(s1_fsq_r[0]) + DEN_W'(s1_fsq_r[1]) + DEN_W'(s1_fsq_r[2]);
  assign den_nxt = BASE + DEN_W'(s1_vsq_r[0]) + DEN_W'(s1_vsq_r[1]) + DEN_W'(s1_vsq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_valid_r[0] <= 1'b0;
    else if (en) dv_valid_r[0] <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= DEN_W'(num_nxt[DEN_W-1:LO_W]);
      dv_q_r[0]   <= '0;
      dv_lo_r[0]  <= num_nxt[LO_W-1:0];
      dv_den_r[0] <= den_nxt;
      dv_vel_r[0] <= s1_vel_r;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    assign trial = {dv_rem_r[k-1], dv_lo_r[k-1][LO_W-1]};
    assign diff  = trial - {1'b0, dv_den_r[k-1]};
    assign ge    = trial >= {1'b0, dv_den_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_valid_r[k] <= 1'b0;
      else if (en) dv_valid_r[k] <= dv_valid_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dv_q_r[k]   <= {dv_q_r[k-1][RATIO_W-2:0], ge};
        dv_lo_r[k]  <= {dv_lo_r[k-1][LO_W-2:0], 1'b0};
        dv_den_r[k] <= dv_den_r[k-1];
        dv_vel_r[k] <= dv_vel_r[k-1];
      end
    end
  end

  // Square root of ratio * 2^24, one root bit per stage.
  logic                  sq_valid_r [0:SQRT_STEPS];
  logic [ROOT_REM_W-1:0] sq_rem_r   [0:SQRT_STEPS];
  logic [ROOT_W-1:0]     sq_root_r  [0:SQRT_STEPS];
  logic [RATIO_W-1:0]    sq_xs_r    [0:SQRT_STEPS];
  logic [RATIO_W-1:0]    sq_ratio_r [0:SQRT_STEPS];
  logic [VEC_W-1:0]      sq_vel_r   [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_valid_r[0] <= 1'b0;
    else if (en) sq_valid_r[0] <= dv_valid_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]   <= '0;
      sq_root_r[0]  <= '0;
      sq_xs_r[0]    <= dv_q_r[DIV_STEPS];
      sq_ratio_r[0] <= dv_q_r[DIV_STEPS];
      sq_vel_r[0]   <= dv_vel_r[DIV_STEPS];
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    logic [ROOT_REM_W+1:0] cur;
    logic [ROOT_REM_W+1:0] trial;
    logic [ROOT_REM_W+1:0] diff;
    logic                  ge;
    assign cur   = {sq_rem_r[k-1], sq_xs_r[k-1][RATIO_W-1:RATIO_W-2]};
    assign trial = (ROOT_REM_W+2)'({sq_root_r[k-1], 2'b01});
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_valid_r[k] <= 1'b0;
      else if (en) sq_valid_r[k] <= sq_valid_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]   <= ge ? diff[ROOT_REM_W-1:0] : cur[ROOT_REM_W-1:0];
        sq_root_r[k]  <= {sq_root_r[k-1][ROOT_W-2:0], ge};
        sq_xs_r[k]    <= {sq_xs_r[k-1][RATIO_W-3:0], 2'b00};
        sq_ratio_r[k] <= sq_ratio_r[k-1];
        sq_vel_r[k]   <= sq_vel_r[k-1];
      end
    end
  end

  logic [RATIO_W-1:0] ratio;
  logic [ROOT_W-1:0]  root;
  assign ratio = sq_ratio_r[SQRT_STEPS];
  assign root  = sq_root_r[SQRT_STEPS];

  // Multiply stages. Wide operands are split at bit 32 into partial products.
  logic [9:0]  m_valid_r;
  logic [VEC_W-1:0] m_vel_r [10];

  always_ff @(posedge clk) begin
    if (!rst_n) m_valid_r <= '0;
    else if (en) m_valid_r <= {m_valid_r[8:0], sq_valid_r[SQRT_STEPS]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_vel_r[0] <= sq_vel_r[SQRT_STEPS];
      for (int i = 1; i < 10; i++) m_vel_r[i] <= m_vel_r[i-1];
    end
  end

  // M1: partial products of ratio squared.
  logic [11:0]        m1_aa_r;
  logic [37:0]        m1_ab_r;
  logic [63:0]        m1_bb_r;
  logic [RATIO_W-1:0] m1_ratio_r;
  logic [ROOT_W-1:0]  m1_root_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_aa_r    <= 12'(ratio[37:32]) * 12'(ratio[37:32]);
      m1_ab_r    <= 38'(ratio[37:32]) * 38'(ratio[31:0]);
      m1_bb_r    <= 64'(ratio[31:0]) * 64'(ratio[31:0]);
      m1_ratio_r <= ratio;
      m1_root_r  <= root;
    end
  end

  // M2: ratio^2 in Q.32.
  logic [76:0]        r2_sum;
  logic [R2_W-1:0]    m2_r2_r;
  logic [RATIO_W-1:0] m2_ratio_r;
  logic [ROOT_W-1:0]  m2_root_r;

  assign r2_sum = 77'({m1_aa_r, 64'b0}) + 77'({m1_ab_r, 33'b0}) + 77'(m1_bb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r2_r    <= r2_sum[74:32];
      m2_ratio_r <= m1_ratio_r;
      m2_root_r  <= m1_root_r;
    end
  end

  // M3: partial products of ratio^3 and of density.
  logic [63:0]       m3_eb_r;
  logic [42:0]       m3_cb_r;
  logic [37:0]       m3_ea_r;
  logic [16:0]       m3_ca_r;
  logic [62:0]       m3_es_r;
  logic [41:0]       m3_cs_r;
  logic [ROOT_W-1:0] m3_root_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_eb_r   <= 64'(m2_r2_r[31:0]) * 64'(m2_ratio_r[31:0]);
      m3_cb_r   <= 43'(m2_r2_r[42:32]) * 43'(m2_ratio_r[31:0]);
      m3_ea_r   <= 38'(m2_r2_r[31:0]) * 38'(m2_ratio_r[37:32]);
      m3_ca_r   <= 17'(m2_r2_r[42:32]) * 17'(m2_ratio_r[37:32]);
      m3_es_r   <= 63'(m2_r2_r[31:0]) * 63'(m2_root_r);
      m3_cs_r   <= 42'(m2_r2_r[42:32]) * 42'(m2_root_r);
      m3_root_r <= m2_root_r;
    end
  end

  // M4: ratio^3 in Q.32 and density in Q16.16.
  logic [81:0]       r3_sum;
  logic [74:0]       dens_sum;
  logic [R3_W-1:0]   m4_r3_r;
  logic [OUT_W-1:0]  m4_dens_r;
  logic [ROOT_W-1:0] m4_root_r;

  assign r3_sum = 82'(m3_eb_r) + 82'({m3_cb_r, 32'b0}) + 82'({m3_ea_r, 32'b0})
                + 82'({m3_ca_r, 64'b0});
  assign dens_sum = 75'(m3_es_r) + 75'({m3_cs_r, 32'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      m4_r3_r   <= r3_sum[79:32];
      m4_dens_r <= OUT_W'(dens_sum[74:44]);
      m4_root_r <= m3_root_r;
    end
  end

  // M5: partial products of ratio^3.5.
  logic [62:0]      m5_hs_r;
  logic [46:0]      m5_gs_r;
  logic [OUT_W-1:0] m5_dens_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m5_hs_r   <= 63'(m4_r3_r[31:0]) * 63'(m4_root_r);
      m5_gs_r   <= 47'(m4_r3_r[47:32]) * 47'(m4_root_r);
      m5_dens_r <= m4_dens_r;
    end
  end

  // M6: ratio^3.5 in Q19.16.
  logic [79:0]      prs_sum;
  logic [PRS_W-1:0] m6_prs_r;
  logic [OUT_W-1:0] m6_dens_r;

  assign prs_sum = 80'(m5_hs_r) + 80'({m5_gs_r, 32'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      m6_prs_r  <= prs_sum[78:44];
      m6_dens_r <= m5_dens_r;
    end
  end

  // M7: times five, and the saturation test for the division by seven.
  logic [37:0]      x5;
  logic [34:0]      m7_x_r;
  logic             m7_sat_r;
  logic [OUT_W-1:0] m7_dens_r;

  assign x5 = {1'b0, m6_prs_r, 2'b00} + 38'(m6_prs_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m7_x_r    <= x5[34:0];
      m7_sat_r  <= x5 >= PRS_SAT;
      m7_dens_r <= m6_dens_r;
    end
  end

  // M8: reciprocal products for the division by seven.
  logic [63:0]      m8_pl_r;
  logic [34:0]      m8_ph_r;
  logic [3:0]       m8_xlo_r;
  logic             m8_sat_r;
  logic [OUT_W-1:0] m8_dens_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m8_pl_r   <= 64'(m7_x_r[31:0]) * 64'(RECIP7);
      m8_ph_r   <= 35'(m7_x_r[34:32]) * 35'(RECIP7);
      m8_xlo_r  <= m7_x_r[3:0];
      m8_sat_r  <= m7_sat_r;
      m8_dens_r <= m7_dens_r;
    end
  end

  // M9: quotient estimate, at most one below the exact quotient.
  logic [66:0]      q_sum;
  logic [31:0]      m9_q0_r;
  logic [3:0]       m9_xlo_r;
  logic             m9_sat_r;
  logic [OUT_W-1:0] m9_dens_r;

  assign q_sum = 67'(m8_pl_r) + 67'({m8_ph_r, 32'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      m9_q0_r   <= q_sum[65:34];
      m9_xlo_r  <= m8_xlo_r;
      m9_sat_r  <= m8_sat_r;
      m9_dens_r <= m8_dens_r;
    end
  end

  // M10: the remainder stays below fourteen, so its low four bits decide the
  // correction.
  logic [3:0]       q7_lo;
  logic [3:0]       rem4;
  logic [OUT_W-1:0] prs_nxt;
  logic [OUT_W-1:0] m10_prs_r;
  logic [OUT_W-1:0] m10_dens_r;

  assign q7_lo = {m9_q0_r[0], 3'b000} - m9_q0_r[3:0];
  assign rem4  = m9_xlo_r - q7_lo;

  always_comb begin
    if (m9_sat_r) prs_nxt = '1;
    else if (rem4 >= 4'd7) prs_nxt = m9_q0_r + 32'd1;
    else prs_nxt = m9_q0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m10_prs_r  <= prs_nxt;
      m10_dens_r <= m9_dens_r;
    end
  end

  assign out_tvalid = m_valid_r[9];
  assign out_tdata  = {m10_prs_r, m10_dens_r, m_vel_r[9]};

endmodule

// ===== test/tb_isentropic_density_pressure_unit.sv =====
// Self-checking testbench for the isentropic density and pressure unit.
`timescale 1ns / 1ps

module tb_isentropic_density_pressure_unit;
  import idp_pkg::*;

  localparam int TB_DIM = 3;
  localparam int LATENCY = 83;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] pressure;
    logic [OUT_W-1:0] density;
    logic [VEL_W-1:0] vel_z;
    logic [VEL_W-1:0] vel_y;
    logic [VEL_W-1:0] vel_x;
  } point_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [VEL_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  logic [VEL_W-1:0] freestream [3];
  point_result_t expected_points [$];
  int errors = 0;
  int cycles = 0;
  bit steady_flow = 0;  // no idling on either side while set

  isentropic_density_pressure_unit #(.DIM(TB_DIM)) DUT (.*);

  always #5 clk = ~clk;

  // floor(a*b / 2^sh), saturating to 64 bits
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> sh;
    if (prod[127:64] != 0) return '1;
    return prod[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic point_result_t flow_at_point(logic [IN_TW-1:0] grads);
    logic signed [17:0] sum;
    logic signed [63:0] f, v;
    logic [63:0] s_loc, s_inf, num, den, r, r2, r3, root, dens, prs;
    logic [VEL_W-1:0] vel [3];
    point_result_t res;
    s_loc = 0;
    s_inf = 0;
    for (int d = 0; d < 3; d++) begin
      vel[d] = '0;
      if (d < TB_DIM) begin
        sum = $signed(freestream[d]) + $signed(grads[d*VEL_W +: VEL_W]);
        if (sum > 18'sd32767) sum = 18'sd32767;
        if (sum < -18'sd32768) sum = -18'sd32768;
        vel[d] = sum[15:0];
        v = sum;
        f = $signed(freestream[d]);
        s_loc += v * v;
        s_inf += f * f;
      end
    end
    num = (64'd5 << 24) + s_inf;
    den = (64'd5 << 24) + s_loc;
    r = (num << 32) / den;
    r2 = mul_shift(r, r, 32);
    r3 = mul_shift(r2, r, 32);
    root = int_sqrt(r << 24);
    dens = mul_shift(r2, root, 44);
    if (dens > 64'hFFFF_FFFF) dens = 64'hFFFF_FFFF;
    prs = mul_shift(r3, root, 44);
    if (prs > 64'hFFFF_FFFF_FFFF) prs = 64'hFFFF_FFFF_FFFF;
    prs = prs * 5 / 7;
    if (prs > 64'hFFFF_FFFF) prs = 64'hFFFF_FFFF;
    res.vel_x = vel[0];
    res.vel_y = vel[1];
    res.vel_z = vel[2];
    res.density = dens[31:0];
    res.pressure = prs[31:0];
    return res;
  endfunction

  function automatic int idle_gap();
    int pick;
    if (steady_flow) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver side backpressure.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= idle_gap();
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_result_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("tb_isentropic_density_pressure_unit NOT OK");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (got.vel_x !== want.vel_x) begin
          $display("%0t: vel_x exp %h got %h", $time, want.vel_x, got.vel_x);
          errors++;
        end
        if (got.vel_y !== want.vel_y) begin
          $display("%0t: vel_y exp %h got %h", $time, want.vel_y, got.vel_y);
          errors++;
        end
        if (got.vel_z !== want.vel_z) begin
          $display("%0t: vel_z exp %h got %h", $time, want.vel_z, got.vel_z);
          errors++;
        end
        if (got.density !== want.density) begin
          $display("%0t: density exp %h got %h", $time, want.density, got.density);
          errors++;
        end
        if (got.pressure !== want.pressure) begin
          $display("%0t: pressure exp %h got %h", $time, want.pressure, got.pressure);
          errors++;
        end
      end
    end
  end

  task automatic send_point(logic [VEL_W-1:0] gx, logic [VEL_W-1:0] gy,
                            logic [VEL_W-1:0] gz);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {gz, gy, gx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_points.insert(expected_points.size(), flow_at_point({gz, gy, gx}));
  endtask

  // Waits until every expected result has arrived and the pipeline is empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [VEL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_COMP) freestream[idx] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_freestream(logic [VEL_W-1:0] fx, logic [VEL_W-1:0] fy,
                                logic [VEL_W-1:0] fz);
    drain();
    write_reg(REG_FS_X, fx);
    write_reg(REG_FS_Y, fy);
    write_reg(REG_FS_Z, fz);
    @(posedge clk);
  endtask

  function automatic logic [VEL_W-1:0] rand_grad(logic [VEL_W-1:0] fs);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return VEL_W'($urandom());
    if (pick < 7) return VEL_W'(-fs + $urandom_range(0, 512) - 256);  // slow local flow
    if (pick < 8) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return VEL_W'($urandom_range(0, 4096) - 2048);
  endfunction

  task automatic test_directed();
    set_freestream(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h1000, 16'hF000, 16'h0800);
    send_point(16'hFFFF, 16'h0001, 16'h5555);
    send_point(16'hAAAA, 16'h5555, 16'hAAAA);
    // Free stream at the edge of the range, so the sums saturate both ways.
    set_freestream(16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h7FFF, 16'h8000, 16'h0001);
    send_point(16'h8001, 16'h7FFF, 16'h8001);
    send_point(16'h8000, 16'h7FFF, 16'h8000);
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h8001, 16'h8000, 16'hFFFF);
    // A write to the unused index must leave the free stream alone.
    drain();
    write_reg(REG_UNUSED, 16'h1234);
    send_point(16'h8001, 16'h8000, 16'h8001);
    send_point(16'h0100, 16'h0200, 16'h0300);
    set_freestream(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random(int count);
    logic [VEL_W-1:0] fx, fy, fz;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          fx = VEL_W'($urandom()); fy = VEL_W'($urandom()); fz = VEL_W'($urandom());
        end
        1: begin
          fx = VEL_W'($urandom_range(0, 8192) - 4096);
          fy = VEL_W'($urandom_range(0, 8192) - 4096);
          fz = VEL_W'($urandom_range(0, 8192) - 4096);
        end
        2: begin
          fx = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          fy = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          fz = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        end
        default: begin
          fx = '0; fy = VEL_W'($urandom()); fz = '0;
        end
      endcase
      set_freestream(fx, fy, fz);
      steady_flow = (phase == 3) || (phase == 6);
      for (int i = 0; i < count / 8; i++)
        send_point(rand_grad(fx), rand_grad(fy), rand_grad(fz));
      steady_flow = 0;
    end
  endtask

  initial begin
    freestream[0] = '0;
    freestream[1] = '0;
    freestream[2] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1700);
    drain();
    if (errors == 0) begin
      $display("tb_isentropic_density_pressure_unit OK");
    end else begin
      $display("tb_isentropic_density_pressure_unit NOT OK");
    end
    $finish;
  end

endmodule
